@@ rtl/water_change_sequencer_assert.svh @@
// assertion helpers for the sequencer rtl
`ifndef WATER_CHANGE_SEQUENCER_ASSERT_SVH
`define WATER_CHANGE_SEQUENCER_ASSERT_SVH

// same-cycle implication, skipped during reset
`define WCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped during reset
`define WCS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wcs_pkg;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_DRAIN_DURATION = 2'd0;
  localparam logic [1:0] REG_MAX_REFILL     = 2'd1;
  localparam logic [1:0] REG_OXY_THRESHOLD  = 2'd2;
  localparam logic [1:0] REG_OXY_DEBOUNCE   = 2'd3;

  localparam logic [31:0] DRAIN_DURATION_RST = 32'd300000;
  localparam logic [31:0] MAX_REFILL_RST     = 32'd300000;
  localparam logic [15:0] OXY_THRESHOLD_RST  = 16'd300;
  localparam logic [31:0] OXY_DEBOUNCE_RST   = 32'd60000;

  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_MANUAL = 2'd1;
  localparam logic [1:0] PHASE_REFILL = 2'd2;
  localparam logic [1:0] PHASE_AUTO   = 2'd3;

  typedef struct packed {
    logic [31:0] drain_duration_ms;
    logic [31:0] refill_limit_ms;
    logic [15:0] oxygen_low_threshold;
    logic [31:0] oxygen_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] oxygen_level;
    logic        oxygen_valid;
    logic        manual_request;
    logic        manual_cancel;
    logic        pump_running;
    logic        valve_in;
    logic        auto_enabled;
    logic        auto_rearmed;
  } item_t;

  typedef struct packed {
    logic       drain_on;
    logic       valve_out;
    logic       in_progress;
    logic [1:0] phase;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/wcs_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wcs_cfg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output wcs_pkg::cfg_t           cfg
);

  logic       wr;
  logic [1:0] idx;

  assign idx = paddr[3:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drain_duration_ms    <= wcs_pkg::DRAIN_DURATION_RST;
      cfg.refill_limit_ms      <= wcs_pkg::MAX_REFILL_RST;
      cfg.oxygen_low_threshold <= wcs_pkg::OXY_THRESHOLD_RST;
      cfg.oxygen_hold_ms       <= wcs_pkg::OXY_DEBOUNCE_RST;
    end else if (wr) begin
      case (idx)
        wcs_pkg::REG_DRAIN_DURATION: cfg.drain_duration_ms    <= pwdata;
        wcs_pkg::REG_MAX_REFILL:     cfg.refill_limit_ms      <= pwdata;
        wcs_pkg::REG_OXY_THRESHOLD:  cfg.oxygen_low_threshold <= pwdata[15:0];
        wcs_pkg::REG_OXY_DEBOUNCE:   cfg.oxygen_hold_ms       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      wcs_pkg::REG_DRAIN_DURATION: prdata = cfg.drain_duration_ms;
      wcs_pkg::REG_MAX_REFILL:     prdata = cfg.refill_limit_ms;
      wcs_pkg::REG_OXY_THRESHOLD:  prdata = {16'd0, cfg.oxygen_low_threshold};
      wcs_pkg::REG_OXY_DEBOUNCE:   prdata = cfg.oxygen_hold_ms;
      default:                     prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/wcs_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wcs_core #(
  parameter int TIMER_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire wcs_pkg::item_t item,
  input  wire wcs_pkg::cfg_t  cfg,
  output wcs_pkg::res_t       res
);

  // compare width covers both the timer and the 32 bit limits
  localparam int CW = (TIMER_BITS > 32) ? TIMER_BITS : 32;

  logic                  manual_active, refill_active, low_tracking;
  logic                  drain_state, progress_flag;
  logic [TIMER_BITS-1:0] manual_start, refill_start, low_since, auto_drain_start;

  logic                  manual_active_next, refill_active_next, low_tracking_next;
  logic                  drain_state_next, progress_flag_next;
  logic [TIMER_BITS-1:0] manual_start_next, refill_start_next;
  logic [TIMER_BITS-1:0] low_since_next, auto_drain_start_next;

  function automatic logic expired(input logic [TIMER_BITS-1:0] now,
                                   input logic [TIMER_BITS-1:0] then,
                                   input logic [31:0] limit);
    logic [TIMER_BITS-1:0] diff;
    diff = now - then;
    return CW'(diff) >= CW'(limit);
  endfunction

  always_comb begin
    logic [TIMER_BITS-1:0] now;
    logic                  valve;
    logic                  stable;
    now    = TIMER_BITS'(item.now_ms);
    valve  = item.valve_in;
    stable = 1'b0;
    manual_active_next    = manual_active;
    refill_active_next    = refill_active;
    low_tracking_next     = low_tracking;
    drain_state_next      = drain_state;
    progress_flag_next    = progress_flag;
    manual_start_next     = manual_start;
    refill_start_next     = refill_start;
    low_since_next        = low_since;
    auto_drain_start_next = auto_drain_start;

    // an invalid sample leaves the sequencer state as it was and passes valve_in through
    if (item.oxygen_valid) begin
      if (item.auto_rearmed) begin
        manual_active_next    = 1'b0;
        refill_active_next    = 1'b0;
        low_tracking_next     = 1'b0;
        low_since_next        = '0;
        auto_drain_start_next = '0;
        progress_flag_next    = 1'b0;
      end

      if (item.manual_request && !manual_active_next && !item.pump_running) begin
        manual_active_next = 1'b1;
        manual_start_next  = now;
        drain_state_next   = 1'b1;
        valve              = 1'b0;
        refill_active_next = 1'b0;
        progress_flag_next = 1'b1;
      end

      if (manual_active_next && item.manual_cancel) begin
        drain_state_next   = 1'b0;
        manual_active_next = 1'b0;
        refill_active_next = 1'b0;
        progress_flag_next = 1'b0;
      end

      if (manual_active_next &&
          expired(now, manual_start_next, cfg.drain_duration_ms)) begin
        drain_state_next   = 1'b0;
        manual_active_next = 1'b0;
        refill_active_next = 1'b1;
        refill_start_next  = now;
        valve              = 1'b1;
        progress_flag_next = 1'b1;
      end

      if (refill_active_next) begin
        if (item.pump_running) begin
          valve = 1'b0;
        end else begin
          valve = 1'b1;
          if (expired(now, refill_start_next, cfg.refill_limit_ms)) begin
            valve              = 1'b0;
            refill_active_next = 1'b0;
            progress_flag_next = 1'b0;
          end
        end
      end

      if (!manual_active_next && !refill_active_next && item.auto_enabled) begin
        if (item.oxygen_level <= cfg.oxygen_low_threshold) begin
          if (!low_tracking_next) begin
            low_tracking_next = 1'b1;
            low_since_next    = now;
          end
        end else begin
          low_tracking_next = 1'b0;
          low_since_next    = '0;
        end
        stable = low_tracking_next &&
                 expired(now, low_since_next, cfg.oxygen_hold_ms);
        if (stable && !drain_state_next && !item.pump_running) begin
          drain_state_next      = 1'b1;
          auto_drain_start_next = now;
          progress_flag_next    = 1'b1;
        end
        if (drain_state_next &&
            expired(now, auto_drain_start_next, cfg.drain_duration_ms)) begin
          drain_state_next      = 1'b0;
          auto_drain_start_next = now;
          low_tracking_next     = 1'b0;
          low_since_next        = '0;
          progress_flag_next    = 1'b0;
        end
      end
    end

    res.drain_on    = drain_state_next;
    res.valve_out   = valve;
    res.in_progress = progress_flag_next;
    if (manual_active_next)      res.phase = wcs_pkg::PHASE_MANUAL;
    else if (refill_active_next) res.phase = wcs_pkg::PHASE_REFILL;
    else if (drain_state_next)   res.phase = wcs_pkg::PHASE_AUTO;
    else                         res.phase = wcs_pkg::PHASE_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_active    <= 1'b0;
      refill_active    <= 1'b0;
      low_tracking     <= 1'b0;
      drain_state      <= 1'b0;
      progress_flag    <= 1'b0;
      manual_start     <= '0;
      refill_start     <= '0;
      low_since        <= '0;
      auto_drain_start <= '0;
    end else if (fire) begin
      manual_active    <= manual_active_next;
      refill_active    <= refill_active_next;
      low_tracking     <= low_tracking_next;
      drain_state      <= drain_state_next;
      progress_flag    <= progress_flag_next;
      manual_start     <= manual_start_next;
      refill_start     <= refill_start_next;
      low_since        <= low_since_next;
      auto_drain_start <= auto_drain_start_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/water_change_sequencer.sv @@
// channel  | handshake             | payload
// ---------+-----------------------+----------------------------------------------
// input    | in_valid / in_stall   | now_ms, oxygen_level, flags, pump, valve, auto
// result   | out_valid / out_stall | drain_on, valve_out, in_progress, phase
// config   | apb psel/penable      | four registers at byte addresses 0, 4, 8, 12
//
// one item per cycle while out_stall is low; an accepted item passes through the
// input register, then one pass through the sequencer logic into the result register
// the sequencer state is updated in the same cycle the result is registered
// rst is synchronous and restores the register defaults and an idle sequencer
// out_stall holds the result register while out_valid is high and, once the input
// register is full, raises in_stall in the same cycle
`timescale 1ns / 1ps
`default_nettype none
`include "water_change_sequencer_assert.svh"
module water_change_sequencer #(
  parameter int TIMER_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] oxygen_level,
  input  wire logic        oxygen_valid,
  input  wire logic        manual_request,
  input  wire logic        manual_cancel,
  input  wire logic        pump_running,
  input  wire logic        valve_in,
  input  wire logic        auto_enabled,
  input  wire logic        auto_rearmed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             drain_on,
  output logic             valve_out,
  output logic             in_progress,
  output logic      [1:0]  phase
);

  wcs_pkg::cfg_t  cfg;
  wcs_pkg::item_t item;
  wcs_pkg::res_t  res_comb;
  wcs_pkg::res_t  res;
  logic           item_valid;
  logic           advance;
  logic           fire;

  assign pready = 1'b1;

  wcs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign advance  = !out_valid || !out_stall;
  assign fire     = item_valid && advance;
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{now_ms, oxygen_level, oxygen_valid, manual_request, manual_cancel,
                pump_running, valve_in, auto_enabled, auto_rearmed};
    end
  end

  wcs_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .cfg  (cfg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_comb;
    end
  end

  assign drain_on    = res.drain_on;
  assign valve_out   = res.valve_out;
  assign in_progress = res.in_progress;
  assign phase       = res.phase;

  // a manual drain always has the relay on and the progress flag set
  `WCS_ASSERT_IMP(a_manual_drain_on, clk, rst,
                  out_valid && phase == wcs_pkg::PHASE_MANUAL,
                  drain_on && in_progress, "manual phase without drain and progress")
  // refill never overlaps a running drain
  `WCS_ASSERT_IMP(a_refill_no_drain, clk, rst,
                  out_valid && phase == wcs_pkg::PHASE_REFILL,
                  !drain_on, "drain relay on during refill")
  // an item that leaves the input register shows up as a result next cycle
  `WCS_ASSERT_NXT(a_fire_result, clk, rst, fire, out_valid, "processed item lost")

endmodule
`default_nettype wire
